// ----- sv/istt_pkg.sv -----
// Shared types, constants and helpers for the inverse-square trajectory tracer.
package istt_pkg;

	localparam int MaxStepsDefault = 64;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MAG_A_X    = 3'd0,
		REG_MAG_A_Y    = 3'd1,
		REG_MAG_B_X    = 3'd2,
		REG_MAG_B_Y    = 3'd3,
		REG_MAG_A_STR  = 3'd4,
		REG_MAG_B_STR  = 3'd5,
		REG_TIME_STEP  = 3'd6,
		REG_TRACE_STEPS = 3'd7
	} cfg_reg_t;

	localparam logic signed [31:0] MagAXReset = 32'sd0;
	localparam logic signed [31:0] MagAYReset = 32'sd35389440;
	localparam logic signed [31:0] MagBXReset = 32'sd125829120;
	localparam logic signed [31:0] MagBYReset = 32'sd35389440;
	localparam logic signed [31:0] MagStrReset = -32'sd327680000;
	localparam logic [15:0] TimeStepReset = 16'd1280;
	localparam logic [6:0] TraceStepsReset = 7'd64;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [15:0] charge;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic last_of_trace;
	} out_word_t;

	// Request/response between the sequencer and the iterative math unit.
	typedef enum logic [1:0] {
		OP_SQRT = 2'd0,
		OP_DIV  = 2'd1
	} op_t;

	typedef struct packed {
		logic start;
		op_t op;
		logic [63:0] a;
		logic [63:0] b;
		logic [5:0] sh;
	} mu_req_t;

	typedef struct packed {
		logic done;
		logic [63:0] res;
	} mu_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7FFFFFFF;
		if (x < -66'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

endpackage

// ----- sv/istt_mathu.sv -----
// Iterative integer square root and shifted saturating divider, shared.
module istt_mathu
	import istt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  mu_req_t req,
	output mu_rsp_t rsp
);

	typedef enum logic [1:0] {S_IDLE, S_SQRT, S_DIVQ, S_DIVF} st_t;

	st_t st_q;
	op_t op_q;
	logic [63:0] x_q, r_q, bit_q;
	logic [63:0] num_q, den_q, q_q, rem_q;
	logic [6:0] cnt_q;
	logic [5:0] fcnt_q;
	logic sat_q;
	logic done_q;

	localparam logic [63:0] Lim = 64'h7FFFFFFF;

	// one sqrt digit
	logic [63:0] rb;
	logic ge_s;
	assign rb = r_q + bit_q;
	assign ge_s = x_q >= rb;

	// one restoring-division bit over the 64-bit integer quotient
	logic [64:0] trial;
	logic [63:0] rem_sh;
	assign rem_sh = {rem_q[62:0], num_q[63]};
	assign trial = {rem_q, num_q[63]} - {1'b0, den_q};

	// fractional bit
	logic [63:0] dmr;
	logic fge;
	logic [64:0] q2;
	assign dmr = den_q - rem_q;
	assign fge = rem_q >= dmr;
	assign q2 = {q_q, fge};

	// sequencer for both operations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			op_q <= OP_SQRT;
			done_q <= 1'b0;
			x_q <= '0; r_q <= '0; bit_q <= '0; num_q <= '0; den_q <= '0;
			q_q <= '0; rem_q <= '0; cnt_q <= '0; fcnt_q <= '0; sat_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (req.start) begin
						op_q <= req.op;
						if (req.op == OP_SQRT) begin
							x_q <= req.a;
							r_q <= '0;
							bit_q <= 64'h4000_0000_0000_0000;
							st_q <= S_SQRT;
						end else begin
							num_q <= req.a;
							den_q <= req.b;
							q_q <= '0;
							rem_q <= '0;
							cnt_q <= 7'd64;
							fcnt_q <= req.sh;
							sat_q <= 1'b0;
							st_q <= S_DIVQ;
						end
					end
				end
				S_SQRT: begin
					if (bit_q == '0) begin
						done_q <= 1'b1;
						st_q <= S_IDLE;
					end else begin
						if (ge_s) begin
							x_q <= x_q - rb;
							r_q <= (r_q >> 1) + bit_q;
						end else begin
							r_q <= r_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				S_DIVQ: begin
					if (cnt_q == '0) begin
						if (q_q > Lim) begin
							sat_q <= 1'b1;
							done_q <= 1'b1;
							st_q <= S_IDLE;
						end else if (fcnt_q == '0) begin
							done_q <= 1'b1;
							st_q <= S_IDLE;
						end else begin
							st_q <= S_DIVF;
						end
					end else begin
						num_q <= {num_q[62:0], 1'b0};
						if (!trial[64]) begin
							rem_q <= trial[63:0];
							q_q <= {q_q[62:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							q_q <= {q_q[62:0], 1'b0};
						end
						cnt_q <= cnt_q - 7'd1;
					end
				end
				S_DIVF: begin
					if (fge) rem_q <= rem_q - dmr;
					else rem_q <= {rem_q[62:0], 1'b0};
					q_q <= q2[63:0];
					fcnt_q <= fcnt_q - 6'd1;
					if (q2 > {1'b0, Lim}) begin
						sat_q <= 1'b1;
						done_q <= 1'b1;
						st_q <= S_IDLE;
					end else if (fcnt_q == 6'd1) begin
						done_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// result of the last operation: root, or clamped quotient
	assign rsp.done = done_q;
	assign rsp.res = (op_q == OP_SQRT) ? r_q : (sat_q ? Lim : q_q);

endmodule

// ----- sv/istt_seq.sv -----
// Step sequencer: force, velocity and position update per trace step.
module istt_seq
	import istt_pkg::*;
#(
	parameter int MAX_STEPS = MaxStepsDefault
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_word_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_word_t          out_data,
	input  logic signed [31:0] mag_ax,
	input  logic signed [31:0] mag_ay,
	input  logic signed [31:0] mag_bx,
	input  logic signed [31:0] mag_by,
	input  logic signed [31:0] str_a,
	input  logic signed [31:0] str_b,
	input  logic [15:0]        dt,
	input  logic [6:0]         nsteps,
	output mu_req_t            req,
	input  mu_rsp_t            rsp,
	input  logic [63:0]        sqrt_res
);

	localparam int CntW = $clog2(MAX_STEPS + 1);

	typedef enum logic [3:0] {
		P_IDLE, P_DELTA, P_SQRT, P_SQRTW, P_DIV, P_DIVW, P_MULX, P_DIVX, P_DIVXW,
		P_DIVY, P_DIVYW, P_ACC, P_UPD1, P_UPD2, P_OUT
	} ph_t;

	ph_t ph_q;
	logic signed [31:0] px_q, py_q, vx_q, vy_q;
	logic signed [15:0] chg_q;
	logic signed [47:0] k_q;
	logic signed [33:0] fx_q, fy_q;
	logic mag_q;
	logic [CntW-1:0] step_q, n_q;
	logic signed [31:0] dx_q, dy_q;
	logic [31:0] ax_q, ay_q;
	logic [63:0] d2_q, dist_q, m_q, prod_q;
	logic [63:0] cx_q;
	logic signed [49:0] dvx_q, dvy_q;
	logic out_valid_q;
	out_word_t out_q;

	logic signed [31:0] mx, my, sk;
	logic signed [32:0] ddx, ddy;
	logic signed [31:0] sdx, sdy;
	logic [47:0] ak;
	logic kneg;
	logic [CntW-1:0] n_clamp;

	assign mx = mag_q ? mag_bx : mag_ax;
	assign my = mag_q ? mag_by : mag_ay;
	assign sk = mag_q ? str_b : str_a;
	assign ddx = {mx[31], mx} - {px_q[31], px_q};
	assign ddy = {my[31], my} - {py_q[31], py_q};
	assign sdx = sat32(66'(ddx));
	assign sdy = sat32(66'(ddy));
	assign kneg = k_q[47];
	assign ak = kneg ? 48'(-k_q) : 48'(k_q);
	assign n_clamp = (nsteps == 7'd0) ? CntW'(1) :
		(nsteps > 7'(MAX_STEPS)) ? CntW'(MAX_STEPS) : CntW'(nsteps);

	// shared unit requests; a coincident point starts no root
	always_comb begin
		req = '0;
		unique case (ph_q)
			P_SQRT: if (d2_q != '0) begin
				req.start = 1'b1; req.op = OP_SQRT; req.a = d2_q;
			end
			P_DIV: begin
				req.start = 1'b1; req.op = OP_DIV; req.a = 64'(ak); req.b = d2_q; req.sh = 6'd24;
			end
			P_DIVX: begin req.start = 1'b1; req.op = OP_DIV; req.a = prod_q; req.b = dist_q; end
			P_DIVY: begin req.start = 1'b1; req.op = OP_DIV; req.a = prod_q; req.b = dist_q; end
			default: req = '0;
		endcase
	end

	logic signed [49:0] tvx, tvy;
	logic signed [57:0] tdx, tdy;
	logic signed [65:0] npx, npy, nvx, nvy;
	logic signed [16:0] sdt;
	assign sdt = {1'b0, dt};

	// next position and velocity from the registered step terms
	assign tvx = (50'(vx_q) * 50'(sdt)) >>> 8;
	assign tvy = (50'(vy_q) * 50'(sdt)) >>> 8;
	assign tdx = (58'(dvx_q) * 58'(sdt)) >>> 9;
	assign tdy = (58'(dvy_q) * 58'(sdt)) >>> 9;
	assign npx = 66'(px_q) + 66'(tvx) + 66'(tdx);
	assign npy = 66'(py_q) + 66'(tvy) + 66'(tdy);
	assign nvx = 66'(vx_q) + 66'(dvx_q);
	assign nvy = 66'(vy_q) + 66'(dvy_q);

	// main step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= P_IDLE;
			out_valid_q <= 1'b0;
			step_q <= '0;
			n_q <= '0;
			mag_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && ph_q != P_OUT) out_valid_q <= 1'b0;
			unique case (ph_q)
				P_IDLE: if (in_valid) begin
					px_q <= in_data.start_x; py_q <= in_data.start_y;
					vx_q <= in_data.vel_x; vy_q <= in_data.vel_y;
					chg_q <= in_data.charge;
					n_q <= n_clamp;
					step_q <= '0;
					mag_q <= 1'b0;
					fx_q <= '0; fy_q <= '0;
					ph_q <= P_DELTA;
				end
				P_DELTA: begin
					dx_q <= sdx; dy_q <= sdy;
					ax_q <= sdx[31] ? 32'(-sdx) : 32'(sdx);
					ay_q <= sdy[31] ? 32'(-sdy) : 32'(sdy);
					k_q <= 48'(sk) * 48'(chg_q);
					ph_q <= P_MULX;
					d2_q <= '0;
				end
				P_MULX: begin
					d2_q <= 64'(ax_q) * 64'(ax_q) + 64'(ay_q) * 64'(ay_q);
					ph_q <= P_SQRT;
				end
				P_SQRT: ph_q <= (d2_q == '0) ? P_ACC : P_SQRTW;
				P_SQRTW: if (rsp.done) begin dist_q <= sqrt_res; ph_q <= P_DIV; end
				P_DIV: ph_q <= P_DIVW;
				P_DIVW: if (rsp.done) begin
					m_q <= rsp.res;
					prod_q <= rsp.res * 64'(ax_q);
					ph_q <= P_DIVX;
				end
				P_DIVX: ph_q <= P_DIVXW;
				P_DIVXW: if (rsp.done) begin
					cx_q <= rsp.res;
					prod_q <= m_q * 64'(ay_q);
					ph_q <= P_DIVY;
				end
				P_DIVY: ph_q <= P_DIVYW;
				P_DIVYW: if (rsp.done) begin
					fx_q <= (kneg != dx_q[31]) ? fx_q - 34'(cx_q) : fx_q + 34'(cx_q);
					fy_q <= (kneg != dy_q[31]) ? fy_q - 34'(rsp.res) : fy_q + 34'(rsp.res);
					ph_q <= P_ACC;
				end
				P_ACC: begin
					if (!mag_q) begin
						mag_q <= 1'b1;
						ph_q <= P_DELTA;
					end else begin
						dvx_q <= (50'(sat32(66'(fx_q))) * 50'(sdt)) >>> 8;
						dvy_q <= (50'(sat32(66'(fy_q))) * 50'(sdt)) >>> 8;
						ph_q <= P_UPD1;
					end
				end
				P_UPD1: begin
					px_q <= sat32(npx); py_q <= sat32(npy);
					vx_q <= sat32(nvx); vy_q <= sat32(nvy);
					ph_q <= P_OUT;
				end
				P_OUT: if (!out_valid_q || !out_stall) begin
					out_valid_q <= 1'b1;
					out_q.pos_x <= px_q;
					out_q.pos_y <= py_q;
					out_q.last_of_trace <= (step_q == n_q - CntW'(1));
					fx_q <= '0; fy_q <= '0; mag_q <= 1'b0;
					if (step_q == n_q - CntW'(1)) ph_q <= P_IDLE;
					else begin step_q <= step_q + CntW'(1); ph_q <= P_DELTA; end
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	assign in_stall = (ph_q != P_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// a result is only raised from the output phase
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ph_q) == P_OUT) else $error("out from wrong phase");
	a_step_rng: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q != P_IDLE |-> step_q < n_q) else $error("step count overrun");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");

endmodule

// ----- sv/inverse_square_trajectory_tracer.sv -----
// Top level: configuration registers, step sequencer and shared sqrt/divide unit.
//  channel | dir | handshake           | payload
//  in      | in  | in_valid/in_stall   | in_data  (in_word_t)
//  out     | out | out_valid/out_stall | out_data (out_word_t)
//  cfg     | in  | cfg_we              | cfg_index, cfg_data
// Each step runs two magnets, each one square root and three divisions
// on the one shared unit (a coincident point skips them); up to MAX_STEPS
// steps (64 by default) a particle.
// in_stall is high from acceptance until the last word enters the output register.
// Reset loads the default magnet layout; no clearing pass.
// A word still waiting at the output holds the sequencer at the next word.
module inverse_square_trajectory_tracer
	import istt_pkg::*;
#(
	parameter int MAX_STEPS = MaxStepsDefault
)(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_word_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_word_t           out_data,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic signed [31:0] ax_q, ay_q, bx_q, by_q, sa_q, sb_q;
	logic [15:0] dt_q;
	logic [6:0] ns_q;
	mu_req_t req;
	mu_rsp_t rsp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= MagAXReset; ay_q <= MagAYReset;
			bx_q <= MagBXReset; by_q <= MagBYReset;
			sa_q <= MagStrReset; sb_q <= MagStrReset;
			dt_q <= TimeStepReset; ns_q <= TraceStepsReset;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MAG_A_X: ax_q <= cfg_data;
				REG_MAG_A_Y: ay_q <= cfg_data;
				REG_MAG_B_X: bx_q <= cfg_data;
				REG_MAG_B_Y: by_q <= cfg_data;
				REG_MAG_A_STR: sa_q <= cfg_data;
				REG_MAG_B_STR: sb_q <= cfg_data;
				REG_TIME_STEP: dt_q <= cfg_data[15:0];
				REG_TRACE_STEPS: ns_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	istt_seq #(.MAX_STEPS(MAX_STEPS)) u_seq (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
		.mag_ax(ax_q), .mag_ay(ay_q), .mag_bx(bx_q), .mag_by(by_q),
		.str_a(sa_q), .str_b(sb_q), .dt(dt_q), .nsteps(ns_q),
		.req, .rsp, .sqrt_res(rsp.res)
	);

	istt_mathu u_math (.clk, .arst_n, .req, .rsp);

endmodule

// ----- verif/inverse_square_trajectory_tracer_test.sv -----
// Testbench for the inverse-square trajectory tracer: directed and random launches, checked word by word.
module inverse_square_trajectory_tracer_test;
	import istt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_data;
	logic      cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	inverse_square_trajectory_tracer uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam longint Q = 65536;
	localparam int MAX_STEPS_TB = MaxStepsDefault;

	// predictor copy of the register file
	longint mag_x [2];
	longint mag_y [2];
	longint mag_k [2];
	longint dt_q;
	int     steps_raw;

	out_word_t expected_points[$];
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_ask = 0;

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	initial begin
		#300ms;
		$display("inverse_square_trajectory_tracer verification failed");
		$finish;
	end

	task automatic report(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic longint clamp32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint unsigned root64(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// force contribution of one magnet on point (px, py)
	function automatic void magnet_pull(input longint px, input longint py,
			input longint mx, input longint my, input longint k,
			inout longint fx, inout longint fy);
		longint dx, dy;
		longint unsigned adx, ady, d2, root_d, ak, m, cx, cy;
		logic [127:0] quo;
		dx = clamp32(mx - px);
		dy = clamp32(my - py);
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		d2 = adx * adx + ady * ady;
		if (d2 == 0) return;  // coincident point adds nothing
		root_d = root64(d2);
		ak = (k < 0) ? -k : k;
		quo = ({64'd0, ak} << 24) / {64'd0, d2};
		m = (quo > 128'h7FFFFFFF) ? 64'h7FFFFFFF : quo[63:0];
		cx = m * adx / root_d;
		cy = m * ady / root_d;
		fx += ((k < 0) != (dx < 0)) ? -longint'(cx) : longint'(cx);
		fy += ((k < 0) != (dy < 0)) ? -longint'(cy) : longint'(cy);
	endfunction

	// trace one launched particle and queue every point it should emit
	function automatic void trace_particle(input in_word_t w);
		longint px, py, vx, vy, chg, fx, fy, dvx, dvy;
		int n;
		out_word_t pt;
		px = w.start_x;
		py = w.start_y;
		vx = w.vel_x;
		vy = w.vel_y;
		chg = w.charge;
		n = steps_raw;
		if (n < 1) n = 1;
		if (n > MAX_STEPS_TB) n = MAX_STEPS_TB;
		for (int s = 0; s < n; s++) begin
			fx = 0;
			fy = 0;
			for (int i = 0; i < 2; i++)
				magnet_pull(px, py, mag_x[i], mag_y[i], mag_k[i] * chg, fx, fy);
			fx = clamp32(fx);
			fy = clamp32(fy);
			dvx = (fx * dt_q) >>> 8;
			dvy = (fy * dt_q) >>> 8;
			px = clamp32(px + ((vx * dt_q) >>> 8) + ((dvx * dt_q) >>> 9));
			py = clamp32(py + ((vy * dt_q) >>> 8) + ((dvy * dt_q) >>> 9));
			vx = clamp32(vx + dvx);
			vy = clamp32(vy + dvy);
			pt.pos_x = px[31:0];
			pt.pos_y = py[31:0];
			pt.last_of_trace = (s == n - 1);
			expected_points = {expected_points, pt};
		end
	endfunction

	// register write; cfg_we is lowered by the caller after the last write
	task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		case (r)
			REG_MAG_A_X:     mag_x[0] = longint'($signed(v));
			REG_MAG_A_Y:     mag_y[0] = longint'($signed(v));
			REG_MAG_B_X:     mag_x[1] = longint'($signed(v));
			REG_MAG_B_Y:     mag_y[1] = longint'($signed(v));
			REG_MAG_A_STR:   mag_k[0] = longint'($signed(v));
			REG_MAG_B_STR:   mag_k[1] = longint'($signed(v));
			REG_TIME_STEP:   dt_q = v[15:0];
			REG_TRACE_STEPS: steps_raw = v[6:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drain the block, then load a full magnet layout, time step and step count
	task automatic set_layout(input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] bx, input logic [31:0] by, input logic [31:0] ka,
			input logic [31:0] kb, input logic [31:0] dt, input logic [31:0] n);
		in_valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		write_reg(REG_MAG_A_X, ax);
		write_reg(REG_MAG_A_Y, ay);
		write_reg(REG_MAG_B_X, bx);
		write_reg(REG_MAG_B_Y, by);
		write_reg(REG_MAG_A_STR, ka);
		write_reg(REG_MAG_B_STR, kb);
		write_reg(REG_TIME_STEP, dt);
		write_reg(REG_TRACE_STEPS, n);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// offer one launch word until taken
	task automatic launch(input in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		trace_particle(w);
	endtask

	function automatic in_word_t make_word(input longint x, input longint y,
			input longint vx, input longint vy, input int chg);
		in_word_t w;
		w.start_x = x[31:0];
		w.start_y = y[31:0];
		w.vel_x = vx[31:0];
		w.vel_y = vy[31:0];
		w.charge = chg[15:0];
		return w;
	endfunction

	// mostly on-screen launches with sane speeds, some raw noise
	function automatic in_word_t random_word();
		in_word_t w;
		if ($urandom_range(99) < 80) begin
			w = make_word(longint'($urandom_range(1920)) * Q + $urandom_range(65535),
				longint'($urandom_range(1080)) * Q + $urandom_range(65535),
				longint'($urandom_range(40)) * Q - 20 * Q + $urandom_range(65535),
				longint'($urandom_range(40)) * Q - 20 * Q + $urandom_range(65535),
				int'($urandom_range(1024)) - 512);
		end else begin
			w = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
		end
		return w;
	endfunction

	// output side: check accepted words, pick the next stall
	always @(posedge clk) begin
		out_word_t exp_pt;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_points.size() == 0) begin
					report($sformatf("unexpected word x=%h y=%h", out_data.pos_x,
						out_data.pos_y));
				end else begin
					exp_pt = expected_points.pop_front();
					if (out_data.pos_x !== exp_pt.pos_x)
						report($sformatf("pos_x %h, want %h", out_data.pos_x, exp_pt.pos_x));
					if (out_data.pos_y !== exp_pt.pos_y)
						report($sformatf("pos_y %h, want %h", out_data.pos_y, exp_pt.pos_y));
					if (out_data.last_of_trace !== exp_pt.last_of_trace)
						report($sformatf("last_of_trace %b, want %b",
							out_data.last_of_trace, exp_pt.last_of_trace));
				end
			end
			if (hold_ask > 0) begin
				hold_ask = hold_ask - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	localparam logic [31:0] SCREEN_Y = 32'd35389440;
	localparam logic [31:0] SCREEN_X = 32'd125829120;
	localparam logic [31:0] STR_DEF = 32'hEC780000;

	// default layout straight out of reset
	task automatic test_reset_layout();
		launch(make_word(960 * Q, 300 * Q, 2 * Q, 0, 256));
		launch(make_word(100 * Q, 800 * Q, 0, -3 * Q, -32768));
	endtask

	// coincident, far and extreme launches
	task automatic test_special_points();
		set_layout(0, SCREEN_Y, SCREEN_X, SCREEN_Y, STR_DEF, 32'h00100000, 1280, 4);
		launch(make_word(0, 540 * Q, 0, 0, 256));
		launch(make_word(1920 * Q, 540 * Q, Q, Q, 32767));
		launch(make_word(-2147483648, -2147483648, -2147483648, -2147483648, -32768));
		launch(make_word(2147483647, 2147483647, 2147483647, 2147483647, 32767));
		launch(make_word(500 * Q, 500 * Q, 5 * Q, -5 * Q, 0));
		launch(make_word(0, 0, 0, 0, 1));
	endtask

	// trace_steps clamping at both ends
	task automatic test_step_count();
		set_layout(0, SCREEN_Y, SCREEN_X, SCREEN_Y, STR_DEF, STR_DEF, 1280, 0);
		launch(make_word(900 * Q, 200 * Q, 0, Q, 256));
		set_layout(0, SCREEN_Y, SCREEN_X, SCREEN_Y, STR_DEF, STR_DEF, 1280, 127);
		launch(make_word(900 * Q, 200 * Q, 0, Q, 256));
		set_layout(0, SCREEN_Y, SCREEN_X, SCREEN_Y, STR_DEF, STR_DEF, 1280, 1);
		launch(make_word(300 * Q, 900 * Q, -Q, 0, -256));
	endtask

	// zero, tiny and huge time steps
	task automatic test_time_step();
		set_layout(0, SCREEN_Y, SCREEN_X, SCREEN_Y, STR_DEF, STR_DEF, 0, 3);
		launch(make_word(700 * Q, 700 * Q, 9 * Q, 9 * Q, 256));
		set_layout(0, SCREEN_Y, SCREEN_X, SCREEN_Y, STR_DEF, STR_DEF, 65535, 3);
		launch(make_word(700 * Q, 700 * Q, 9 * Q, 9 * Q, 256));
		set_layout(0, SCREEN_Y, SCREEN_X, SCREEN_Y, STR_DEF, STR_DEF, 1, 3);
		launch(make_word(700 * Q, 700 * Q, 9 * Q, 9 * Q, 256));
	endtask

	// strength and magnet position extremes
	task automatic test_strength_extremes();
		set_layout(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 1280, 5);
		launch(make_word(0, 0, 0, 0, 32767));
		launch(make_word(Q, -Q, Q, Q, -32768));
		set_layout(10 * Q, 10 * Q, 12 * Q, 10 * Q, 32'h80000000, 32'h7FFFFFFF, 256, 5);
		launch(make_word(11 * Q, 10 * Q, 0, 0, 32767));
		launch(make_word(10 * Q + 1, 10 * Q, 0, 0, -32768));
	endtask

	// long receiver hold-off while launches keep coming
	task automatic test_backpressure();
		set_layout(0, SCREEN_Y, SCREEN_X, SCREEN_Y, STR_DEF, STR_DEF, 1280, 2);
		hold_ask = 3000;
		for (int i = 0; i < 3; i++) launch(random_word());
	endtask

	// random layouts and launches under three idling mixes
	task automatic test_random();
		int n;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 56 : 0;
			recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 24 : 0;
			for (int blk = 0; blk < 4; blk++) begin
				n = ($urandom_range(9) == 0) ? 64 : $urandom_range(6, 1);
				if ($urandom_range(3) == 0)
					set_layout($urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom_range(65535), n);
				else
					set_layout($urandom_range(1920) * Q, $urandom_range(1080) * Q,
						$urandom_range(1920) * Q, $urandom_range(1080) * Q,
						-(longint'($urandom_range(20000)) * Q / 4),
						-(longint'($urandom_range(20000)) * Q / 4),
						$urandom_range(2560, 1), n);
				for (int i = 0; i < 8; i++) launch(random_word());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mag_x[0] = 0;
		mag_y[0] = 540 * Q;
		mag_x[1] = 1920 * Q;
		mag_y[1] = 540 * Q;
		mag_k[0] = -327680000;
		mag_k[1] = -327680000;
		dt_q = 1280;
		steps_raw = 64;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_layout();
		test_special_points();
		test_step_count();
		test_time_step();
		test_strength_extremes();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (error_count == 0)
			$display("inverse_square_trajectory_tracer verification clean");
		else
			$display("inverse_square_trajectory_tracer verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/istt_pkg.sv
sv/istt_mathu.sv
sv/istt_seq.sv
sv/inverse_square_trajectory_tracer.sv
verif/inverse_square_trajectory_tracer_test.sv
